// ===== rtl/square_spiral_index_coordinate_map_core_assert.svh =====
// assertion macros for the square spiral index and coordinate map core
`ifndef SQUARE_SPIRAL_INDEX_COORDINATE_MAP_CORE_ASSERT_SVH
`define SQUARE_SPIRAL_INDEX_COORDINATE_MAP_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SSIC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssic check failed");

// next-cycle implication, off during reset
`define SSIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssic check failed");

// next-cycle implication, active during reset
`define SSIC_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssic reset check failed");

`endif

// ===== rtl/ssic_pkg.sv =====
// shared constants and types of the square spiral index and coordinate map
package ssic_pkg;

  localparam int unsigned SSIC_INDEX_BITS = 62;

  localparam int unsigned INDEX_W     = 62;
  localparam int unsigned COORD_IN_W  = 31;
  localparam int unsigned COORD_OUT_W = 32;
  localparam int unsigned SIDE_W      = 32;
  localparam int unsigned ADD_W       = 35;
  localparam int unsigned PROD_W      = 64;
  localparam int unsigned CALC_W      = 35;

  localparam logic MODE_TO_XY    = 1'b0;
  localparam logic MODE_TO_INDEX = 1'b1;

  typedef struct packed {
    logic valid;
    logic mode;
  } ssic_tag_t;

  typedef struct packed {
    logic signed [COORD_OUT_W-1:0] pos_x;
    logic signed [COORD_OUT_W-1:0] pos_y;
    logic [INDEX_W-1:0]            pos_index;
  } ssic_result_t;

endpackage

// ===== rtl/ssic_if.sv =====
// query and result channel interfaces
interface ssic_query_if import ssic_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [INDEX_W-1:0]           query_index;
  logic signed [COORD_IN_W-1:0] query_x;
  logic signed [COORD_IN_W-1:0] query_y;

  modport source (output valid, mode, query_index, query_x, query_y, input ready);
  modport sink (input valid, mode, query_index, query_x, query_y, output ready);
endinterface

interface ssic_result_if import ssic_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_OUT_W-1:0] pos_x;
  logic signed [COORD_OUT_W-1:0] pos_y;
  logic [INDEX_W-1:0]            pos_index;

  modport source (output valid, pos_x, pos_y, pos_index, input ready);
  modport sink (input valid, pos_x, pos_y, pos_index, output ready);
endinterface

// ===== rtl/square_spiral_index_coordinate_map_core.sv =====
// Square spiral map between a step index and grid coordinates. Each query
// transaction carries a mode: mode 0 turns query_index (low INDEX_BITS bits)
// into pos_x/pos_y, mode 1 turns query_x/query_y into pos_index; the unused
// result fields are zero. The core takes one query per cycle while input
// ready is high and returns results in order through three stages for
// the coordinate side (side select, 32x32 squaring, final add), one
// integer square root stage per root bit, and one output register
// stage that also decodes the spiral arm. A two-entry output buffer keeps
// input ready high while one finished result waits; ready drops only when
// both entries are full, and the whole pipeline then holds.
module square_spiral_index_coordinate_map_core import ssic_pkg::*; #(
  parameter int unsigned INDEX_BITS = SSIC_INDEX_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  ssic_query_if.sink    in_chan,
  ssic_result_if.source out_chan
);

  localparam int unsigned RB = (INDEX_BITS + 1) / 2;
  localparam int unsigned RW = RB + 2;

  logic                  en;
  ssic_tag_t             in_tag, xy_tag, root_tag;
  logic [INDEX_BITS-1:0] xy_idx, xy_pidx, root_pidx;
  logic [RB-1:0]         root_val;
  logic [RW-1:0]         root_rem;

  assign in_tag       = '{valid: in_chan.valid, mode: in_chan.mode};
  assign in_chan.ready = en;

  ssic_xy2i #(.INDEX_BITS(INDEX_BITS)) u_xy2i (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .tag_i       (in_tag),
    .query_index (in_chan.query_index),
    .query_x     (in_chan.query_x),
    .query_y     (in_chan.query_y),
    .tag_o       (xy_tag),
    .idx_o       (xy_idx),
    .pidx_o      (xy_pidx)
  );

  ssic_root #(.INDEX_BITS(INDEX_BITS)) u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (xy_tag),
    .idx_i  (xy_idx),
    .pidx_i (xy_pidx),
    .tag_o  (root_tag),
    .root_o (root_val),
    .rem_o  (root_rem),
    .pidx_o (root_pidx)
  );

  ssic_outq #(.INDEX_BITS(INDEX_BITS)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (root_tag),
    .root_i    (root_val),
    .rem_i     (root_rem),
    .pidx_i    (root_pidx),
    .en_o      (en),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .pos_x     (out_chan.pos_x),
    .pos_y     (out_chan.pos_y),
    .pos_index (out_chan.pos_index)
  );

endmodule

// ===== rtl/ssic_xy2i.sv =====
// coordinate to index pipeline: ring side select, squaring, final add
module ssic_xy2i import ssic_pkg::*; #(
  parameter int unsigned INDEX_BITS = SSIC_INDEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  ssic_tag_t                    tag_i,
  input  logic [INDEX_W-1:0]           query_index,
  input  logic signed [COORD_IN_W-1:0] query_x,
  input  logic signed [COORD_IN_W-1:0] query_y,
  output ssic_tag_t                    tag_o,
  output logic [INDEX_BITS-1:0]        idx_o,
  output logic [INDEX_BITS-1:0]        pidx_o
);

  localparam logic signed [ADD_W-1:0] ZERO = '0;
  localparam logic signed [ADD_W-1:0] ONE  = ADD_W'(1);

  logic signed [ADD_W-1:0] xw, yw, ax, ay, s_c, add_c;
  logic [PROD_W-1:0]       sq_nxt, sum_nxt;

  ssic_tag_t               tag1_r, tag2_r, tag3_r;
  logic [INDEX_BITS-1:0]   idx1_r, idx2_r, idx3_r;
  logic [SIDE_W-1:0]       s1_r;
  logic signed [ADD_W-1:0] add1_r, add2_r;
  logic [PROD_W-1:0]       sq2_r;
  logic [INDEX_BITS-1:0]   pidx3_r;

  assign xw = ADD_W'(query_x);
  assign yw = ADD_W'(query_y);
  assign ax = (xw < ZERO) ? -xw : xw;
  assign ay = (yw < ZERO) ? -yw : yw;

  // ring side of the point, square root of the ring start and offset
  always_comb begin
    s_c   = ZERO;
    add_c = ZERO;
    priority if (ax > ay) begin
      if (xw > ZERO) begin
        s_c   = (xw <<< 1) - ONE;
        add_c = yw + xw - ONE;
      end else begin
        s_c   = -(xw <<< 1);
        add_c = -xw - yw;
      end
    end else if (ax < ay) begin
      if (yw > ZERO) begin
        s_c   = (yw <<< 1) - ONE;
        add_c = s_c + yw - xw;
      end else begin
        s_c   = -(yw <<< 1);
        add_c = s_c + xw - yw;
      end
    end else if (xw > ZERO && yw > ZERO) begin
      s_c   = (xw <<< 1) - ONE;
      add_c = s_c;
    end else if (xw > ZERO) begin
      s_c   = (xw <<< 1) + ONE;
      add_c = -ONE;
    end else if (yw > ZERO) begin
      s_c   = yw <<< 1;
      add_c = ZERO;
    end else begin
      s_c   = -(xw <<< 1);
      add_c = s_c;
    end
  end

  assign sq_nxt  = PROD_W'(s1_r) * PROD_W'(s1_r);
  assign sum_nxt = sq2_r + PROD_W'(add2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r  <= query_index[INDEX_BITS-1:0];
      s1_r    <= s_c[SIDE_W-1:0];
      add1_r  <= add_c;
      idx2_r  <= idx1_r;
      sq2_r   <= sq_nxt;
      add2_r  <= add1_r;
      idx3_r  <= idx2_r;
      pidx3_r <= sum_nxt[INDEX_BITS-1:0];
    end
  end

  assign tag_o  = tag3_r;
  assign idx_o  = idx3_r;
  assign pidx_o = pidx3_r;

endmodule

// ===== rtl/ssic_root.sv =====
// pipelined integer square root, one root bit per stage, remainder kept
module ssic_root import ssic_pkg::*; #(
  parameter int unsigned INDEX_BITS = SSIC_INDEX_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  ssic_tag_t                            tag_i,
  input  logic [INDEX_BITS-1:0]                idx_i,
  input  logic [INDEX_BITS-1:0]                pidx_i,
  output ssic_tag_t                            tag_o,
  output logic [(INDEX_BITS+1)/2-1:0]          root_o,
  output logic [(INDEX_BITS+1)/2+1:0]          rem_o,
  output logic [INDEX_BITS-1:0]                pidx_o
);

  localparam int unsigned RB   = (INDEX_BITS + 1) / 2;
  localparam int unsigned RW   = RB + 2;
  localparam int unsigned RADW = 2 * RB;

  ssic_tag_t             tag_r  [RB];
  logic [RADW-1:0]       rad_r  [RB];
  logic [RB-1:0]         root_r [RB];
  logic [RW-1:0]         rem_r  [RB];
  logic [INDEX_BITS-1:0] pidx_r [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    ssic_tag_t             tag_in;
    logic [RADW-1:0]       rad_in;
    logic [RB-1:0]         root_in;
    logic [RW-1:0]         rem_in;
    logic [INDEX_BITS-1:0] pidx_in;
    logic [RW-1:0]         rem_sh;
    logic [RW-1:0]         trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rad_in  = RADW'(idx_i);
      assign root_in = '0;
      assign rem_in  = '0;
      assign pidx_in = pidx_i;
    end else begin : g_next
      assign tag_in  = tag_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign pidx_in = pidx_r[k-1];
    end

    // bring down the next two radicand bits and try 4*root+1
    assign rem_sh = {rem_in[RW-3:0], rad_in[RADW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in << 2;
        root_r[k] <= {root_in[RB-2:0], ge};
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        pidx_r[k] <= pidx_in;
      end
    end
  end

  assign tag_o  = tag_r[RB-1];
  assign root_o = root_r[RB-1];
  assign rem_o  = rem_r[RB-1];
  assign pidx_o = pidx_r[RB-1];

endmodule

// ===== rtl/ssic_outq.sv =====
// arm decode to x and y, result select and two-entry output buffer
module ssic_outq import ssic_pkg::*; #(
  parameter int unsigned INDEX_BITS = SSIC_INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssic_tag_t                     tag_i,
  input  logic [(INDEX_BITS+1)/2-1:0]   root_i,
  input  logic [(INDEX_BITS+1)/2+1:0]   rem_i,
  input  logic [INDEX_BITS-1:0]         pidx_i,
  output logic                          en_o,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_OUT_W-1:0] pos_x,
  output logic signed [COORD_OUT_W-1:0] pos_y,
  output logic [INDEX_W-1:0]            pos_index
);

  localparam logic signed [CALC_W-1:0] ONE = CALC_W'(1);

  logic signed [CALC_W-1:0] se, re, he, x_c, y_c;
  ssic_result_t             res_c;
  ssic_result_t             head_r, skid_r;
  logic                     head_valid_r, head_valid_nxt;
  logic                     skid_valid_r, skid_valid_nxt;
  logic                     push, pop;
  logic                     head_load_pipe, head_load_skid, skid_load;

  assign se = $signed(CALC_W'(root_i));
  assign re = $signed(CALC_W'(rem_i));
  assign he = se >>> 1;

  always_comb begin
    x_c = '0;
    y_c = '0;
    if (root_i[0]) begin
      if (re <= se) begin
        // right side, going up
        x_c = he + ONE;
        y_c = re - he;
      end else begin
        // top side, going left
        y_c = he + ONE;
        x_c = he + ONE + se - re;
      end
    end else begin
      if (re <= se) begin
        // left side, going down
        x_c = -he;
        y_c = he - re;
      end else begin
        // bottom side, going right
        y_c = -he;
        x_c = re - se - he;
      end
    end
  end

  always_comb begin
    res_c = '0;
    if (tag_i.mode == MODE_TO_INDEX) begin
      res_c.pos_index = INDEX_W'(pidx_i);
    end else begin
      res_c.pos_x = x_c[COORD_OUT_W-1:0];
      res_c.pos_y = y_c[COORD_OUT_W-1:0];
    end
  end

  assign en_o = !skid_valid_r;
  assign push = en_o && tag_i.valid;
  assign pop  = head_valid_r && out_ready;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_load_pipe = 1'b0;
    head_load_skid = 1'b0;
    skid_load      = 1'b0;
    if (pop) begin
      head_valid_nxt = skid_valid_r || push;
      head_load_skid = skid_valid_r;
      head_load_pipe = !skid_valid_r && push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      if (head_valid_r) begin
        skid_valid_nxt = 1'b1;
        skid_load      = 1'b1;
      end else begin
        head_valid_nxt = 1'b1;
        head_load_pipe = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_load_skid) begin
      head_r <= skid_r;
    end else if (head_load_pipe) begin
      head_r <= res_c;
    end
    if (skid_load) begin
      skid_r <= res_c;
    end
  end

  assign out_valid = head_valid_r;
  assign pos_x     = head_r.pos_x;
  assign pos_y     = head_r.pos_y;
  assign pos_index = head_r.pos_index;

endmodule

// ===== rtl/ssic_checker.sv =====
// port-level checker for the spiral map core and its bind
`include "square_spiral_index_coordinate_map_core_assert.svh"

module ssic_checker import ssic_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_OUT_W-1:0] pos_x,
  input logic signed [COORD_OUT_W-1:0] pos_y,
  input logic [INDEX_W-1:0]            pos_index
);

  logic out_stall;
  logic full_stall;

  assign out_stall  = out_valid && !out_ready;
  assign full_stall = !in_ready && !out_ready;

  // no result right after reset
  `SSIC_ASSERT_RESET(a_reset_empty, !rst_n, !out_valid)
  // back-pressure on the input only when a result is waiting
  `SSIC_ASSERT_SAME(a_ready_needs_result, !in_ready, out_valid)
  // a full buffer stays full until a result transaction completes
  `SSIC_ASSERT_NEXT(a_full_holds, full_stall, !in_ready)
  // a stalled result holds
  `SSIC_ASSERT_NEXT(a_out_hold, out_stall,
    out_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_index))

endmodule

bind square_spiral_index_coordinate_map_core ssic_checker u_ssic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pos_x     (out_chan.pos_x),
  .pos_y     (out_chan.pos_y),
  .pos_index (out_chan.pos_index)
);
